// ----- hw/rtl/ptc_pkg.sv -----
// Shared types, codes and keyword tables for the Pascal token classifier.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptc_pkg;

  localparam int LINE_MAX_COLS_DEF = 4096;
  localparam int WORD_CHARS_DEF    = 15;
  localparam int COL_OUT_W         = 13;
  localparam int KW_CHARS          = 14;
  localparam int FIFO_DEPTH        = 4;
  localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

  // Scan modes
  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_SLASH     = 4'd1;
  localparam logic [3:0] M_BRACE     = 4'd2;
  localparam logic [3:0] M_PAREN     = 4'd3;
  localparam logic [3:0] M_LINECMT   = 4'd4;
  localparam logic [3:0] M_BRACEBODY = 4'd5;
  localparam logic [3:0] M_DIRBODY   = 4'd6;
  localparam logic [3:0] M_PARENBODY = 4'd7;
  localparam logic [3:0] M_PARENSTAR = 4'd8;
  localparam logic [3:0] M_STRING    = 4'd9;
  localparam logic [3:0] M_HEX       = 4'd10;
  localparam logic [3:0] M_NUMBER    = 4'd11;
  localparam logic [3:0] M_IDENT     = 4'd12;

  // Span styles
  localparam logic [2:0] S_KEYWORD   = 3'd0;
  localparam logic [2:0] S_TYPE      = 3'd1;
  localparam logic [2:0] S_DIRECTIVE = 3'd2;
  localparam logic [2:0] S_COMMENT   = 3'd3;
  localparam logic [2:0] S_STRING    = 3'd4;
  localparam logic [2:0] S_IDENT     = 3'd5;
  localparam logic [2:0] S_NUMBER    = 3'd6;
  localparam logic [2:0] S_FUNCTION  = 3'd7;

  // Comment carry states
  localparam logic [1:0] C_NONE  = 2'd0;
  localparam logic [1:0] C_BRACE = 2'd1;
  localparam logic [1:0] C_DIR   = 2'd2;
  localparam logic [1:0] C_PAREN = 2'd3;

  // Lookahead stages for a pending identifier
  localparam logic [1:0] LA_NONE  = 2'd0;
  localparam logic [1:0] LA_BLANK = 2'd1;
  localparam logic [1:0] LA_PAREN = 2'd2;

  typedef logic [KW_CHARS*8-1:0] kw_lit_t;

  localparam int KW_N = 57;
  localparam int TY_N = 11;

  localparam kw_lit_t KW_ROM [KW_N] = '{
    "absolute", "and", "array", "asm", "begin", "case", "comp", "const", "div", "do",
    "downto", "else", "end", "extended", "external", "false", "far", "file", "for",
    "forward", "function", "goto", "if", "implementation", "in", "inline", "interface",
    "interrupt", "label", "mod", "near", "nil", "not", "of", "or", "overlay", "packed",
    "procedure", "program", "record", "repeat", "set", "shl", "shr", "single", "text",
    "then", "to", "true", "type", "unit", "until", "uses", "var", "while", "with", "xor"
  };

  localparam kw_lit_t TY_ROM [TY_N] = '{
    "boolean", "byte", "char", "double", "integer", "longint", "pointer", "real",
    "shortint", "string", "word"
  };

  typedef struct packed {
    logic [COL_OUT_W-1:0] span_start;
    logic [COL_OUT_W-1:0] span_end;
    logic [2:0]           span_style;
  } span_t;

  // Spans produced by one accepted beat
  typedef struct packed {
    logic [1:0] cnt;
    span_t      s0;
    span_t      s1;
    logic [1:0] carry;
  } push_t;

  typedef struct packed {
    span_t      span;
    logic [1:0] carry;
    logic       last;
  } entry_t;

  // Count the characters of a right-aligned literal
  function automatic logic [4:0] lit_len(input kw_lit_t lit);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < KW_CHARS; i++) begin
      if (lit[i*8 +: 8] != 8'd0) n = n + 5'd1;
    end
    return n;
  endfunction

  // Compare a lowercased word (char i at bits i*8) against one literal
  function automatic logic lit_match(input kw_lit_t w, input logic [4:0] len,
                                     input kw_lit_t lit);
    logic [4:0] l;
    logic       ok;
    int         j;
    l  = lit_len(lit);
    ok = (len == l);
    for (int i = 0; i < KW_CHARS; i++) begin
      j = int'(l) - 1 - i;
      if (j >= 0) ok = ok && (w[i*8 +: 8] == lit[j*8 +: 8]);
    end
    return ok;
  endfunction

  function automatic logic kw_hit(input kw_lit_t w, input logic [4:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < KW_N; k++) hit = hit | lit_match(w, len, KW_ROM[k]);
    return hit;
  endfunction

  function automatic logic ty_hit(input kw_lit_t w, input logic [4:0] len);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < TY_N; k++) hit = hit | lit_match(w, len, TY_ROM[k]);
    return hit;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ptc_scanner.sv -----
// Scanner state and single-beat classification logic.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptc_scanner #(
  parameter int LINE_MAX_COLS = ptc_pkg::LINE_MAX_COLS_DEF,
  parameter int WORD_CHARS    = ptc_pkg::WORD_CHARS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           take,
  input  wire logic [20:0]    code_point,
  input  wire logic           char_valid,
  input  wire logic           line_end,
  output ptc_pkg::push_t      push
);
  import ptc_pkg::*;

  localparam int COL_W = $clog2(LINE_MAX_COLS + 1);
  localparam int WL_W  = $clog2(WORD_CHARS + 1);
  localparam int IX_W  = $clog2(WORD_CHARS);
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_MAX_COLS);

  logic [1:0]       cs_r, cs_nxt;
  logic [3:0]       mode_r, mode_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COL_W-1:0] ts_r, ts_nxt;
  logic [WL_W-1:0]  wl_r, wl_nxt;
  logic [COL_W-1:0] wend_r, wend_nxt;
  logic [COL_W-1:0] wstart_r, wstart_nxt;
  logic [1:0]       la_r, la_nxt;
  logic [7:0]       wch_r [WORD_CHARS];
  logic [7:0]       wch_nxt [WORD_CHARS];
  push_t            res;

  function automatic logic [COL_W-1:0] sat_inc(input logic [COL_W-1:0] v);
    return (v >= COL_MAX) ? COL_MAX : v + COL_W'(1);
  endfunction

  function automatic logic [COL_OUT_W-1:0] to_out(input logic [COL_W-1:0] v);
    logic [COL_W+COL_OUT_W-1:0] t;
    t = {{COL_OUT_W{1'b0}}, v};
    return t[COL_OUT_W-1:0];
  endfunction

  // Append a span unless it is empty or both slots are used
  function automatic push_t add(input push_t l, input logic [COL_W-1:0] s,
                                input logic [COL_W-1:0] e, input logic [2:0] st);
    push_t o;
    span_t sp;
    o  = l;
    sp = '{span_start: to_out(s), span_end: to_out(e), span_style: st};
    if (e > s) begin
      if (l.cnt == 2'd0) begin
        o.s0  = sp;
        o.cnt = 2'd1;
      end else if (l.cnt == 2'd1) begin
        o.s1  = sp;
        o.cnt = 2'd2;
      end
    end
    return o;
  endfunction

  function automatic logic [4:0] len5(input logic [WL_W-1:0] v);
    logic [WL_W+4:0] t;
    t = {5'd0, v};
    return t[4:0];
  endfunction

  // Classify and step the whole beat: character first, then line end
  always_comb begin
    logic [7:0]       ch;
    logic             asc, dig, alp, wrd, hx, blank;
    logic             do_idle;
    logic [COL_W-1:0] col;
    kw_lit_t          wv;
    logic             kw, ty;
    cs_nxt     = cs_r;
    mode_nxt   = mode_r;
    col_nxt    = col_r;
    ts_nxt     = ts_r;
    wl_nxt     = wl_r;
    wend_nxt   = wend_r;
    wstart_nxt = wstart_r;
    la_nxt     = la_r;
    wch_nxt    = wch_r;
    res        = '0;
    ch         = code_point[7:0];
    asc        = (code_point[20:7] == 14'd0);
    dig        = asc && ch >= "0" && ch <= "9";
    alp        = asc && ((ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z"));
    wrd        = alp || dig || (asc && ch == "_");
    hx         = dig || (asc && ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F")));
    blank      = asc && (ch == " " || ch == 8'h09);
    do_idle    = 1'b0;
    col        = col_r;
    wv         = '0;
    kw         = 1'b0;
    ty         = 1'b0;

    if (char_valid) begin
      // Resolve a pending identifier
      if (la_nxt == LA_PAREN) begin
        res    = add(res, wstart_nxt, wend_nxt,
                     (asc && ch == "*") ? S_IDENT : S_FUNCTION);
        la_nxt = LA_NONE;
      end else if (la_nxt == LA_BLANK) begin
        if (asc && ch == "(") begin
          la_nxt = LA_PAREN;
        end else begin
          res    = add(res, wstart_nxt, wend_nxt, S_IDENT);
          la_nxt = LA_NONE;
        end
      end

      case (mode_r)
        M_IDLE: do_idle = 1'b1;
        M_SLASH: begin
          if (asc && ch == "/") mode_nxt = M_LINECMT;
          else do_idle = 1'b1;
        end
        M_BRACE: begin
          if (asc && ch == "$") begin
            mode_nxt = M_DIRBODY;
            cs_nxt   = C_DIR;
          end else if (asc && ch == "}") begin
            res      = add(res, ts_r, sat_inc(col), S_COMMENT);
            cs_nxt   = C_NONE;
            mode_nxt = M_IDLE;
          end else begin
            mode_nxt = M_BRACEBODY;
            cs_nxt   = C_BRACE;
          end
        end
        M_PAREN: begin
          if (asc && ch == "*") begin
            mode_nxt = M_PARENBODY;
            cs_nxt   = C_PAREN;
          end else begin
            do_idle = 1'b1;
          end
        end
        M_LINECMT: ;
        M_BRACEBODY, M_DIRBODY: begin
          if (asc && ch == "}") begin
            res      = add(res, ts_r, sat_inc(col),
                           (mode_r == M_DIRBODY) ? S_DIRECTIVE : S_COMMENT);
            cs_nxt   = C_NONE;
            mode_nxt = M_IDLE;
          end
        end
        M_PARENBODY: begin
          if (asc && ch == "*") mode_nxt = M_PARENSTAR;
        end
        M_PARENSTAR: begin
          if (asc && ch == ")") begin
            res      = add(res, ts_r, sat_inc(col), S_COMMENT);
            cs_nxt   = C_NONE;
            mode_nxt = M_IDLE;
          end else if (!(asc && ch == "*")) begin
            mode_nxt = M_PARENBODY;
          end
        end
        M_STRING: begin
          if (asc && ch == "'") begin
            res      = add(res, ts_r, sat_inc(col), S_STRING);
            mode_nxt = M_IDLE;
          end
        end
        M_HEX: begin
          if (!hx) begin
            res     = add(res, ts_r, col, S_STRING);
            do_idle = 1'b1;
          end
        end
        M_NUMBER: begin
          if (!(alp || dig || (asc && ch == "."))) begin
            res     = add(res, ts_r, col, S_NUMBER);
            do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (wrd) begin
            if (wl_r < WL_W'(WORD_CHARS)) begin
              wch_nxt[wl_r[IX_W-1:0]] = (alp && ch <= "Z") ? ch + 8'd32 : ch;
              wl_nxt = wl_r + WL_W'(1);
            end
          end else begin
            for (int i = 0; i < KW_CHARS; i++) wv[i*8 +: 8] = wch_r[i];
            kw         = kw_hit(wv, len5(wl_r));
            ty         = ty_hit(wv, len5(wl_r));
            wend_nxt   = col;
            wstart_nxt = ts_r;
            mode_nxt   = M_IDLE;
            if (kw) res = add(res, ts_r, col, S_KEYWORD);
            else if (ty) res = add(res, ts_r, col, S_TYPE);
            else if (blank) la_nxt = LA_BLANK;
            else if (asc && ch == "(") la_nxt = LA_PAREN;
            else res = add(res, ts_r, col, S_IDENT);
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // Start a new token
      if (do_idle) begin
        ts_nxt = col;
        if (asc && ch == "/") mode_nxt = M_SLASH;
        else if (asc && ch == "{") mode_nxt = M_BRACE;
        else if (asc && ch == "(") mode_nxt = M_PAREN;
        else if (asc && ch == "'") mode_nxt = M_STRING;
        else if (asc && ch == "#") mode_nxt = M_HEX;
        else if (dig || (asc && ch == "$")) mode_nxt = M_NUMBER;
        else if (alp || (asc && ch == "_")) begin
          mode_nxt   = M_IDENT;
          wch_nxt[0] = (ch <= "Z") ? ch + 8'd32 : ch;
          wl_nxt     = WL_W'(1);
        end else mode_nxt = M_IDLE;
      end
      col_nxt = sat_inc(col_r);
    end

    if (line_end) begin
      // Decide a pending identifier with nothing left on the line
      if (la_nxt == LA_BLANK) res = add(res, wstart_nxt, wend_nxt, S_IDENT);
      else if (la_nxt == LA_PAREN) res = add(res, wstart_nxt, wend_nxt, S_FUNCTION);
      la_nxt = LA_NONE;

      case (mode_nxt)
        M_BRACE: begin
          cs_nxt = C_BRACE;
          res    = add(res, ts_nxt, col_nxt, S_COMMENT);
        end
        M_LINECMT, M_BRACEBODY, M_PARENBODY, M_PARENSTAR:
          res = add(res, ts_nxt, col_nxt, S_COMMENT);
        M_DIRBODY: res = add(res, ts_nxt, col_nxt, S_DIRECTIVE);
        M_STRING, M_HEX: res = add(res, ts_nxt, col_nxt, S_STRING);
        M_NUMBER: res = add(res, ts_nxt, col_nxt, S_NUMBER);
        M_IDENT: begin
          wv = '0;
          for (int i = 0; i < KW_CHARS; i++) wv[i*8 +: 8] = wch_nxt[i];
          wend_nxt   = col_nxt;
          wstart_nxt = ts_nxt;
          if (kw_hit(wv, len5(wl_nxt))) res = add(res, ts_nxt, col_nxt, S_KEYWORD);
          else if (ty_hit(wv, len5(wl_nxt))) res = add(res, ts_nxt, col_nxt, S_TYPE);
          else res = add(res, ts_nxt, col_nxt, S_IDENT);
        end
        default: ;
      endcase

      col_nxt = '0;
      ts_nxt  = '0;
      case (cs_nxt)
        C_BRACE: mode_nxt = M_BRACEBODY;
        C_DIR:   mode_nxt = M_DIRBODY;
        C_PAREN: mode_nxt = M_PARENBODY;
        default: mode_nxt = M_IDLE;
      endcase
    end
    res.carry = cs_nxt;
  end

  // Advance scanner state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r     <= C_NONE;
      mode_r   <= M_IDLE;
      col_r    <= '0;
      ts_r     <= '0;
      wl_r     <= '0;
      wend_r   <= '0;
      wstart_r <= '0;
      la_r     <= LA_NONE;
    end else if (take) begin
      cs_r     <= cs_nxt;
      mode_r   <= mode_nxt;
      col_r    <= col_nxt;
      ts_r     <= ts_nxt;
      wl_r     <= wl_nxt;
      wend_r   <= wend_nxt;
      wstart_r <= wstart_nxt;
      la_r     <= la_nxt;
    end
  end

  // Word buffer holds payload only
  always_ff @(posedge clk) begin
    if (take) wch_r <= wch_nxt;
  end

  always_comb begin
    push = res;
    if (!take) push.cnt = 2'd0;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ptc_span_fifo.sv -----
// Small result queue: takes up to two spans per beat, issues one per cycle while head_ready is high.
// Depends on ptc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptc_span_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire ptc_pkg::push_t push,
  output logic              room,
  output ptc_pkg::entry_t   head,
  output logic              head_valid,
  input  wire logic         head_ready
);
  import ptc_pkg::*;

  entry_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                   pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rp_r];
  assign pop        = head_valid && head_ready;
  // Keep space for two spans from the next beat
  assign room       = (cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wp_nxt  = wp_r + FIFO_PTR_W'(push.cnt);
    rp_nxt  = rp_r + FIFO_PTR_W'(pop);
    cnt_nxt = cnt_r + FIFO_CNT_W'(push.cnt) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Write spans in order, marking the last one of the beat
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wp_r] <= '{span: push.s0, carry: push.carry, last: (push.cnt == 2'd1)};
    end
    if (push.cnt == 2'd2) begin
      mem_r[wp_r + FIFO_PTR_W'(1)] <= '{span: push.s1, carry: push.carry, last: 1'b1};
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/pascal_token_classifier.sv -----
// Top level of the Pascal token classifier: scanner plus result queue.
// Depends on ptc_pkg, ptc_scanner and ptc_span_fifo.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one source character per beat
//   with char_valid and line_end flags. Output channel (out_valid/out_ready)
//   carries styled spans: start column, exclusive end column, style, the
//   comment carry state after the beat, and last_of_run on the final span
//   a beat produced. A beat yields zero, one or two spans.
//   A span enters the span queue with the beat that completes it;
//   identifiers may be completed up to three beats after their last letter.
//   Throughput: one beat per cycle while the 4-entry span queue has room for
//   two more spans; beats that yield two spans drain at one span per cycle
//   while out_ready is high, set by the single output port of the queue.
//   Reset (rst_n low, synchronous) clears the scanner to no comment, column
//   zero, and empties the queue. When the receiver stalls, the queue fills and
//   in_ready drops once fewer than two free entries remain.
`timescale 1ns / 1ps
`default_nettype none
module pascal_token_classifier #(
  parameter int LINE_MAX_COLS = ptc_pkg::LINE_MAX_COLS_DEF,
  parameter int WORD_CHARS    = ptc_pkg::WORD_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [20:0] in_code_point,
  input  wire logic        in_char_valid,
  input  wire logic        in_line_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [12:0]      out_span_start,
  output logic [12:0]      out_span_end,
  output logic [2:0]       out_span_style,
  output logic [1:0]       out_carry_state,
  output logic             out_last_of_run
);
  import ptc_pkg::*;

  push_t  push;
  entry_t head;
  logic   room;
  logic   take;

  assign in_ready = room;
  assign take     = in_valid && room;

  ptc_scanner #(
    .LINE_MAX_COLS (LINE_MAX_COLS),
    .WORD_CHARS    (WORD_CHARS)
  ) u_scanner (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .code_point (in_code_point),
    .char_valid (in_char_valid),
    .line_end   (in_line_end),
    .push       (push)
  );

  ptc_span_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .head       (head),
    .head_valid (out_valid),
    .head_ready (out_ready)
  );

  assign out_span_start  = head.span.span_start;
  assign out_span_end    = head.span.span_end;
  assign out_span_style  = head.span.span_style;
  assign out_carry_state = head.carry;
  assign out_last_of_run = head.last;

endmodule
`default_nettype wire

// ----- hw/rtl/ptc_checker.sv -----
// Port-level checks for the Pascal token classifier, bound to the top level.
// Depends on pascal_token_classifier ports only.
`timescale 1ns / 1ps
`default_nettype none
module ptc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [12:0] out_span_start,
  input wire logic [12:0] out_span_end,
  input wire logic [2:0]  out_span_style,
  input wire logic        out_last_of_run
);

  // Hold a stalled span beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_span_start) &&
    $stable(out_span_end) && $stable(out_span_style) && $stable(out_last_of_run))
    else $error("stalled span changed");

  // Never issue an empty span
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_span_end > out_span_start)
    else $error("empty span issued");

  // Input backpressure only when spans are queued
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty queue");

  // Queue is empty right after reset
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("span valid after reset");

endmodule

bind pascal_token_classifier ptc_checker u_ptc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_span_start  (out_span_start),
  .out_span_end    (out_span_end),
  .out_span_style  (out_span_style),
  .out_last_of_run (out_last_of_run)
);
`default_nettype wire

// ----- tb/pascal_token_classifier_test.sv -----
// Testbench for pascal_token_classifier: directed lines, then random Pascal-like source,
// with spans checked against a line-scanning predictor kept in this file or a typed-in row expectation.
// Depends on ptc_pkg and the pascal_token_classifier RTL.
`timescale 1ns / 1ps
module pascal_token_classifier_test;
  import ptc_pkg::*;

  localparam int COL_LIMIT  = LINE_MAX_COLS_DEF;
  localparam int WORD_KEEP  = WORD_CHARS_DEF;
  localparam int RAND_ITEMS = 750;
  localparam int STALL_MAX  = 5000;
  localparam int LONG_HOLD  = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [20:0] in_code_point = '0;
  logic        in_char_valid = 1'b0;
  logic        in_line_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] out_span_start;
  logic [12:0] out_span_end;
  logic [2:0]  out_span_style;
  logic [1:0]  out_carry_state;
  logic        out_last_of_run;

  pascal_token_classifier dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_code_point(in_code_point), .in_char_valid(in_char_valid),
    .in_line_end(in_line_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_span_start(out_span_start), .out_span_end(out_span_end),
    .out_span_style(out_span_style), .out_carry_state(out_carry_state),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scanner state mirrored from the block
  logic [3:0] scan;
  logic [1:0] carry;
  logic [1:0] pend;
  int         col, tok_start, wlen, wend, wstart;
  logic [7:0] wch [WORD_KEEP];
  span_t      beat_spans[$];
  entry_t     span_q[$];

  bit    is_kw[string];
  bit    is_ty[string];
  string kw_names[$] = '{"absolute", "and", "array", "asm", "begin", "case", "comp",
    "const", "div", "do", "downto", "else", "end", "extended", "external", "false", "far",
    "file", "for", "forward", "function", "goto", "if", "implementation", "in", "inline",
    "interface", "interrupt", "label", "mod", "near", "nil", "not", "of", "or", "overlay",
    "packed", "procedure", "program", "record", "repeat", "set", "shl", "shr", "single",
    "text", "then", "to", "true", "type", "unit", "until", "uses", "var", "while", "with",
    "xor"};
  string ty_names[$] = '{"boolean", "byte", "char", "double", "integer", "longint",
    "pointer", "real", "shortint", "string", "word"};

  int  errors = 0;
  int  n_beats = 0;
  int  n_spans = 0;
  int  n_lines = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  rx_burst = 0;
  int  quiet_cycles = 0;

  function automatic int sat(int v);
    return (v >= COL_LIMIT) ? COL_LIMIT : v + 1;
  endfunction

  function automatic bit is_digit(int c); return c >= "0" && c <= "9"; endfunction
  function automatic bit is_alpha(int c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction
  function automatic bit is_alnum(int c); return is_alpha(c) || is_digit(c); endfunction
  function automatic bit is_hexc(int c);
    return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function void add_span(int s, int e, logic [2:0] st);
    span_t x;
    if (e > s && beat_spans.size() < 2) begin
      x.span_start = s[12:0];
      x.span_end   = e[12:0];
      x.span_style = st;
      beat_spans.push_back(x);
    end
  endfunction

  function void push_char(int c);
    if (c >= "A" && c <= "Z") c = c + 32;
    if (wlen < WORD_KEEP) begin
      wch[wlen] = c[7:0];
      wlen++;
    end
  endfunction

  // Close the word at column e; return 1 when it is neither keyword nor type
  function bit close_word(int e);
    string w;
    w = "";
    wend = e;
    wstart = tok_start;
    scan = M_IDLE;
    for (int i = 0; i < wlen; i++) w = $sformatf("%s%c", w, wch[i]);
    if (is_kw.exists(w)) begin
      add_span(wstart, wend, S_KEYWORD);
      return 1'b0;
    end
    if (is_ty.exists(w)) begin
      add_span(wstart, wend, S_TYPE);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function void start_token(int c, int at);
    tok_start = at;
    scan = M_IDLE;
    if (c == "/") scan = M_SLASH;
    else if (c == "{") scan = M_BRACE;
    else if (c == "(") scan = M_PAREN;
    else if (c == "'") scan = M_STRING;
    else if (c == "#") scan = M_HEX;
    else if (is_digit(c) || c == "$") scan = M_NUMBER;
    else if (is_alpha(c) || c == "_") begin
      scan = M_IDENT;
      wlen = 0;
      push_char(c);
    end
  endfunction

  function void brace_char(int c, int at, logic [2:0] st);
    if (c == "}") begin
      add_span(tok_start, sat(at), st);
      carry = C_NONE;
      scan = M_IDLE;
    end
  endfunction

  function void scan_char(int c);
    int at;
    at = col;
    // Resolve an identifier waiting on blank or '('
    if (pend == LA_PAREN) begin
      add_span(wstart, wend, (c == "*") ? S_IDENT : S_FUNCTION);
      pend = LA_NONE;
    end else if (pend == LA_BLANK) begin
      if (c == "(") pend = LA_PAREN;
      else begin
        add_span(wstart, wend, S_IDENT);
        pend = LA_NONE;
      end
    end
    case (scan)
      M_IDLE: start_token(c, at);
      M_SLASH: begin
        if (c == "/") scan = M_LINECMT;
        else start_token(c, at);
      end
      M_BRACE: begin
        if (c == "$") begin
          scan = M_DIRBODY;
          carry = C_DIR;
        end else begin
          scan = M_BRACEBODY;
          carry = C_BRACE;
          brace_char(c, at, S_COMMENT);
        end
      end
      M_PAREN: begin
        if (c == "*") begin
          scan = M_PARENBODY;
          carry = C_PAREN;
        end else start_token(c, at);
      end
      M_LINECMT: ;
      M_BRACEBODY: brace_char(c, at, S_COMMENT);
      M_DIRBODY: brace_char(c, at, S_DIRECTIVE);
      M_PARENBODY: if (c == "*") scan = M_PARENSTAR;
      M_PARENSTAR: begin
        if (c == ")") begin
          add_span(tok_start, sat(at), S_COMMENT);
          carry = C_NONE;
          scan = M_IDLE;
        end else if (c != "*") scan = M_PARENBODY;
      end
      M_STRING: begin
        if (c == "'") begin
          add_span(tok_start, sat(at), S_STRING);
          scan = M_IDLE;
        end
      end
      M_HEX: begin
        if (!is_hexc(c)) begin
          add_span(tok_start, at, S_STRING);
          start_token(c, at);
        end
      end
      M_NUMBER: begin
        if (!is_alnum(c) && c != ".") begin
          add_span(tok_start, at, S_NUMBER);
          start_token(c, at);
        end
      end
      M_IDENT: begin
        if (is_alnum(c) || c == "_") push_char(c);
        else begin
          if (close_word(at)) begin
            if (c == " " || c == "\t") pend = LA_BLANK;
            else if (c == "(") pend = LA_PAREN;
            else add_span(wstart, wend, S_IDENT);
          end
          start_token(c, at);
        end
      end
      default: start_token(c, at);
    endcase
    col = sat(col);
  endfunction

  function void end_line();
    if (pend == LA_BLANK) add_span(wstart, wend, S_IDENT);
    else if (pend == LA_PAREN) add_span(wstart, wend, S_FUNCTION);
    pend = LA_NONE;
    case (scan)
      M_BRACE: begin
        carry = C_BRACE;
        add_span(tok_start, col, S_COMMENT);
      end
      M_LINECMT, M_BRACEBODY, M_PARENBODY, M_PARENSTAR:
        add_span(tok_start, col, S_COMMENT);
      M_DIRBODY: add_span(tok_start, col, S_DIRECTIVE);
      M_STRING, M_HEX: add_span(tok_start, col, S_STRING);
      M_NUMBER: add_span(tok_start, col, S_NUMBER);
      M_IDENT: if (close_word(col)) add_span(wstart, wend, S_IDENT);
      default: ;
    endcase
    col = 0;
    tok_start = 0;
    case (carry)
      C_BRACE: scan = M_BRACEBODY;
      C_DIR:   scan = M_DIRBODY;
      C_PAREN: scan = M_PARENBODY;
      default: scan = M_IDLE;
    endcase
  endfunction

  // Typed-in expectation for the last beat of a directed row
  bit     fix_on;
  int     fix_n;
  entry_t fix_e;

  // Advance the mirrored scanner by one accepted beat and queue its spans
  function void classify_beat(int cp, bit cv, bit le, bit use_fix);
    entry_t e;
    beat_spans.delete();
    if (cv) scan_char(cp);
    if (le) end_line();
    if (use_fix) begin
      if (fix_n > 0) span_q.push_back(fix_e);
    end else begin
      foreach (beat_spans[k]) begin
        e.span  = beat_spans[k];
        e.carry = carry;
        e.last  = (k == beat_spans.size() - 1);
        span_q.push_back(e);
      end
    end
  endfunction

  // Offer one beat, with an optional gap first; returns at the accepting edge
  task send_beat(input int cp, input bit cv, input bit le, input bit use_fix);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_code_point <= cp[20:0];
    in_char_valid <= cv;
    in_line_end   <= le;
    do @(posedge clk); while (!in_ready);
    classify_beat(cp, cv, le, use_fix);
    if (cv || le) n_beats++;
  endtask

  int line_q[$];

  // Send the line held in line_q; the line end rides on the last character or stands alone
  task send_line(input bit sep_end, input bit use_fix);
    for (int i = 0; i < line_q.size(); i++)
      send_beat(line_q[i], 1'b1, !sep_end && i == line_q.size() - 1,
                use_fix && !sep_end && i == line_q.size() - 1);
    if (sep_end || line_q.size() == 0) send_beat(0, 1'b0, 1'b1, use_fix);
    n_lines++;
  endtask

  function void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function void put_word(string s);
    int c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if ($urandom_range(0, 2) == 0 && is_alpha(c)) c = c - 32;
      line_q.push_back(c);
    end
  endfunction

  function void put_body(int n);
    for (int i = 0; i < n; i++) line_q.push_back($urandom_range(32, 126));
  endfunction

  function void put_token();
    int n;
    case ($urandom_range(0, 15))
      0: put_word(kw_names[$urandom_range(0, kw_names.size() - 1)]);
      1: put_word(ty_names[$urandom_range(0, ty_names.size() - 1)]);
      2: begin
        n = $urandom_range(1, 20);
        line_q.push_back($urandom_range(0, 4) == 0 ? "_" : "a" + $urandom_range(0, 25));
        for (int i = 1; i < n; i++)
          case ($urandom_range(0, 3))
            0: line_q.push_back("A" + $urandom_range(0, 25));
            1: line_q.push_back("0" + $urandom_range(0, 9));
            2: line_q.push_back("_");
            default: line_q.push_back("a" + $urandom_range(0, 25));
          endcase
        case ($urandom_range(0, 5))
          0: put_text("(");
          1: put_text(" (");
          2: put_text(" (*");
          3: put_text("(*");
          default: ;
        endcase
      end
      3: begin
        if ($urandom_range(0, 2) == 0) put_text("$");
        else line_q.push_back("0" + $urandom_range(0, 9));
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++)
          line_q.push_back($urandom_range(0, 5) == 0 ? "." : "0" + $urandom_range(0, 9));
        if ($urandom_range(0, 3) == 0) put_text("e5");
      end
      4: begin
        put_text("#");
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
          line_q.push_back($urandom_range(0, 1) ? "0" + $urandom_range(0, 9)
                                                  : "A" + $urandom_range(0, 5));
      end
      5: begin
        put_text("'");
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) line_q.push_back("a" + $urandom_range(0, 25));
        if ($urandom_range(0, 3) != 0) put_text("'");
      end
      6: begin
        put_text("{");
        put_body($urandom_range(0, 4));
        if ($urandom_range(0, 1)) put_text("}");
      end
      7: begin
        put_text("{$");
        put_body($urandom_range(0, 4));
        if ($urandom_range(0, 1)) put_text("}");
      end
      8: begin
        put_text("(*");
        put_body($urandom_range(0, 4));
        if ($urandom_range(0, 1)) put_text("**)");
        else if ($urandom_range(0, 1)) put_text("*)");
      end
      9: begin
        put_text("//");
        put_body($urandom_range(0, 5));
      end
      10: put_text($urandom_range(0, 1) ? "/" : "(");
      11: put_text($urandom_range(0, 1) ? " " : "\t");
      12: line_q.push_back($urandom_range(0, 1114111));
      13: line_q.push_back($urandom_range(32, 126));
      default: begin
        n = $urandom_range(0, 2);
        line_q.push_back(n == 0 ? ")" : n == 1 ? "*" : "}");
      end
    endcase
  endfunction

  function void make_line(int ntok);
    line_q.delete();
    for (int t = 0; t < ntok; t++) begin
      put_token();
      if ($urandom_range(0, 1)) put_text(" ");
    end
  endfunction

  // Directed row: text, extra code point, end style, typed expectation
  task run_row(input string txt, input int extra, input int kind, input bit typed,
               input int tn, input int s, input int e, input logic [2:0] st,
               input logic [1:0] cs);
    fix_n = tn;
    fix_e.span.span_start = s[12:0];
    fix_e.span.span_end   = e[12:0];
    fix_e.span.span_style = st;
    fix_e.carry = cs;
    fix_e.last  = 1'b1;
    if (kind == 2) send_beat(0, 1'b0, 1'b0, typed);
    else begin
      line_q.delete();
      put_text(txt);
      if (extra >= 0) line_q.push_back(extra);
      send_line(kind == 1, typed);
    end
  endtask

  // Wait with the sender quiet until every queued span is out
  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (span_q.size() != 0);
  endtask

  // Receiver: check each accepted span, stall in random bursts or one long hold
  always @(posedge clk) begin
    entry_t want;
    if (rst_n && out_valid && out_ready) begin
      n_spans++;
      if (span_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("span with nothing expected: start %0d end %0d style %0d",
                   out_span_start, out_span_end, out_span_style);
      end else begin
        want = span_q.pop_front();
        if (out_span_start !== want.span.span_start || out_span_end !== want.span.span_end
            || out_span_style !== want.span.span_style || out_carry_state !== want.carry
            || out_last_of_run !== want.last) begin
          errors++;
          if (errors <= 10)
            $display("span mismatch: expected %0d..%0d style %0d carry %0d last %0d, got %0d..%0d style %0d carry %0d last %0d",
                     want.span.span_start, want.span.span_end, want.span.span_style,
                     want.carry, want.last, out_span_start, out_span_end,
                     out_span_style, out_carry_state, out_last_of_run);
        end
      end
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (!idle_on) begin
      out_ready <= 1'b1;
    end else if (rx_burst > 0) begin
      rx_burst--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      rx_burst = $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("watchdog: no beat moved for %0d cycles, %0d spans pending",
               quiet_cycles, span_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int rand_beats;
    int start_beats;
    bit hold_done;
    bit pause_done;
    foreach (kw_names[i]) is_kw[kw_names[i]] = 1'b1;
    foreach (ty_names[i]) is_ty[ty_names[i]] = 1'b1;
    scan = M_IDLE;
    carry = C_NONE;
    pend = LA_NONE;
    col = 0;
    tok_start = 0;
    wlen = 0;
    wend = 0;
    wstart = 0;
    hold_done = 1'b0;
    pause_done = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines
    run_row("x", -1, 0, 1, 1, 0, 1, S_IDENT, C_NONE);
    run_row("", -1, 1, 1, 0, 0, 0, S_IDENT, C_NONE);
    run_row("", -1, 2, 1, 0, 0, 0, S_IDENT, C_NONE);
    run_row("f (", -1, 0, 0, 0, 0, 0, S_IDENT, C_NONE);
    run_row("{$i}", -1, 0, 1, 1, 0, 4, S_DIRECTIVE, C_NONE);
    run_row("(*", -1, 0, 1, 1, 0, 2, S_COMMENT, C_PAREN);
    run_row("*)", -1, 1, 0, 0, 0, 0, S_IDENT, C_NONE);
    run_row("'a", -1, 0, 1, 1, 0, 2, S_STRING, C_NONE);
    run_row("#1F//x", -1, 0, 0, 0, 0, 0, S_IDENT, C_NONE);
    run_row("ab", 'h10FFFF, 0, 1, 1, 0, 2, S_IDENT, C_NONE);
    run_row("{", -1, 0, 1, 1, 0, 1, S_COMMENT, C_BRACE);
    run_row("}", -1, 0, 0, 0, 0, 0, S_IDENT, C_NONE);

    // Random source lines
    start_beats = n_beats;
    rand_beats = 0;
    while (rand_beats < RAND_ITEMS) begin
      if (!hold_done && rand_beats > 150) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && rand_beats > 300) begin
        drain();
        pause_done = 1'b1;
      end
      if (rand_beats > RAND_ITEMS - 120) idle_on = 1'b0;
      if ($urandom_range(0, 20) == 0) send_beat(0, 1'b0, 1'b0, 1'b0);
      make_line($urandom_range(0, 8));
      send_line($urandom_range(0, 3) == 0, 1'b0);
      rand_beats = n_beats - start_beats;
    end
    in_valid <= 1'b0;

    while (span_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d beats over %0d lines, checked %0d spans, %0d mismatches.",
             n_beats, n_lines, n_spans, errors);
    if (errors == 0 && span_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
